// ===== hdl/adc_channel_scan_sequencer_defines.svh =====
// Assertion macros for the ADC channel scan sequencer.
// No dependencies; included by adc_channel_scan_sequencer.sv, the RTL file that carries assertions.
`ifndef ADC_CHANNEL_SCAN_SEQUENCER_DEFINES_SVH
`define ADC_CHANNEL_SCAN_SEQUENCER_DEFINES_SVH

`ifndef ASSERT_OFF
// checked at every clock edge once reset is released
`define ACSS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// checked at every clock edge, reset included
`define ACSS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define ACSS_ASSERT(lbl, prop, msg)
`define ACSS_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== hdl/acss_pkg.sv =====
// Shared types and constants of the ADC channel scan sequencer.
// No dependencies; imported by acss_core and adc_channel_scan_sequencer.
package acss_pkg;

    localparam int MAX_CHANNELS = 16;
    localparam int SLOT_W       = $clog2(MAX_CHANNELS);
    localparam int CH_W         = 4;
    localparam int CODE_W       = 32;
    localparam int CFG_IDX_W    = 4;
    localparam int CFG_DATA_W   = 8;

    localparam logic [8:0] WAIT_LIMIT = 9'h0FF;
    localparam logic [8:0] WAIT_MAX   = 9'h1FF;
    localparam logic [7:0] SETTLE_MAX = 8'hFF;

    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_TICKS  = 4'd1;

    localparam logic [4:0] CHANNEL_COUNT_RST = 5'd2;
    localparam logic [7:0] SETTLE_TICKS_RST  = 8'd8;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_OPEN   = 3'd1,
        PH_SETTLE = 3'd2,
        PH_TRIG   = 3'd3,
        PH_READI  = 3'd4,
        PH_READV  = 3'd5,
        PH_CLOSE  = 3'd6,
        PH_PARKED = 3'd7
    } t_phase;

    typedef enum logic [2:0] {
        FN_TICK      = 3'd0,
        FN_TEST_REQ  = 3'd1,
        FN_TEST_TRIG = 3'd2,
        FN_RENEW     = 3'd3,
        FN_READ      = 3'd4
    } t_func;

    typedef struct packed {
        logic [4:0] channel_count;
        logic [7:0] settle_ticks;
    } t_cfg;

    typedef struct packed {
        logic [2:0]        func;
        logic              current_ready_n;
        logic              voltage_ready_n;
        logic [CODE_W-1:0] adc_data;
        logic [CH_W-1:0]   test_channel;
    } t_item;

    typedef struct packed {
        logic [2:0]        state_code;
        logic              mux_open;
        logic [CH_W-1:0]   mux_channel;
        logic              trigger_convert;
        logic              store_current;
        logic              store_voltage;
        logic [CODE_W-1:0] sample_code;
        logic              reinit;
        logic              test_parked;
        logic [CODE_W-1:0] read_current;
        logic [CODE_W-1:0] read_voltage;
    } t_result;

endpackage

// ===== hdl/acss_core.sv =====
// Scan state machine and per-channel code store of the scan sequencer.
// Depends on acss_pkg; one transaction is processed per i_step cycle.
module acss_core
    import acss_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    t_phase          r_phase, n_phase;
    logic [7:0]      r_settle_count, n_settle_count;
    logic [8:0]      r_wait_count, n_wait_count;
    logic [CH_W-1:0] r_scan_channel, n_scan_channel;
    logic [CH_W-1:0] r_pinned_channel, n_pinned_channel;
    logic [CH_W-1:0] r_saved_channel, n_saved_channel;
    logic            r_test_mode, n_test_mode;
    logic            r_test_switched, n_test_switched;
    logic            r_parked_flag, n_parked_flag;

    logic [CODE_W-1:0]       r_cur_codes [MAX_CHANNELS];
    logic [CODE_W-1:0]       r_volt_codes [MAX_CHANNELS];
    logic [MAX_CHANNELS-1:0] r_cur_valid;
    logic [MAX_CHANNELS-1:0] r_volt_valid;

    t_func             w_func;
    logic              w_tick;
    logic              w_timeout;
    logic [8:0]        w_wait_inc;
    logic [7:0]        w_settle_inc;
    logic [4:0]        w_next_ch;
    logic [SLOT_W-1:0] w_slot;
    logic              w_st_cur;
    logic              w_st_volt;
    logic              w_data_nz;

    assign w_func       = t_func'(i_item.func);
    assign w_tick       = (w_func == FN_TICK);
    assign w_timeout    = (r_wait_count >= WAIT_LIMIT);
    assign w_wait_inc   = (r_wait_count == WAIT_MAX) ? r_wait_count : r_wait_count + 9'd1;
    assign w_settle_inc = (r_settle_count == SETTLE_MAX) ? r_settle_count
                                                         : r_settle_count + 8'd1;
    assign w_next_ch    = {1'b0, r_scan_channel} + 5'd1;
    assign w_slot       = r_scan_channel[SLOT_W-1:0];
    assign w_data_nz    = (i_item.adc_data != '0);
    assign w_st_cur     = w_tick && (r_phase == PH_READI) && !i_item.current_ready_n
                          && w_data_nz;
    assign w_st_volt    = w_tick && (r_phase == PH_READV) && !i_item.voltage_ready_n
                          && w_data_nz;

    // next state
    always_comb begin
        n_phase          = r_phase;
        n_settle_count   = r_settle_count;
        n_wait_count     = r_wait_count;
        n_scan_channel   = r_scan_channel;
        n_pinned_channel = r_pinned_channel;
        n_saved_channel  = r_saved_channel;
        n_test_mode      = r_test_mode;
        n_test_switched  = r_test_switched;
        n_parked_flag    = r_parked_flag;
        case (w_func)
            FN_TICK: begin
                case (r_phase)
                    PH_IDLE: begin
                        n_phase        = PH_OPEN;
                        n_settle_count = '0;
                        n_scan_channel = '0;
                    end
                    PH_OPEN: begin
                        n_settle_count = '0;
                        n_phase        = PH_SETTLE;
                        if (r_test_mode) begin
                            n_test_switched = 1'b1;
                            n_scan_channel  = r_pinned_channel;
                        end
                    end
                    PH_SETTLE: begin
                        if (w_settle_inc >= i_cfg.settle_ticks) begin
                            n_phase = (r_test_mode && r_test_switched) ? PH_PARKED : PH_TRIG;
                            n_settle_count = '0;
                        end else begin
                            n_settle_count = w_settle_inc;
                        end
                    end
                    PH_TRIG: begin
                        n_phase      = PH_READI;
                        n_wait_count = '0;
                    end
                    PH_READI, PH_READV: begin
                        if ((r_phase == PH_READI) ? !i_item.current_ready_n
                                                  : !i_item.voltage_ready_n) begin
                            n_phase = (r_phase == PH_READI) ? PH_READV : PH_CLOSE;
                        end else begin
                            n_wait_count = w_wait_inc;
                            if (w_timeout) begin
                                n_phase         = PH_IDLE;
                                n_scan_channel  = '0;
                                n_saved_channel = '0;
                                n_test_mode     = 1'b0;
                                n_test_switched = 1'b0;
                            end
                        end
                    end
                    PH_CLOSE: begin
                        if (!r_test_mode) begin
                            n_scan_channel = (w_next_ch >= i_cfg.channel_count) ? '0
                                                                                : w_next_ch[3:0];
                            n_phase = PH_OPEN;
                        end else if (r_parked_flag) begin
                            n_phase = PH_PARKED;
                        end else begin
                            n_scan_channel = r_pinned_channel;
                            n_phase        = PH_OPEN;
                        end
                    end
                    PH_PARKED: n_parked_flag = 1'b1;
                    default: ;
                endcase
            end
            FN_TEST_REQ: begin
                n_saved_channel  = r_scan_channel;
                n_pinned_channel = i_item.test_channel;
                n_test_mode      = 1'b1;
                n_parked_flag    = 1'b0;
            end
            FN_TEST_TRIG: n_phase = PH_TRIG;
            FN_RENEW: begin
                n_scan_channel  = r_saved_channel;
                n_test_mode     = 1'b0;
                n_test_switched = 1'b0;
                n_phase         = PH_IDLE;
            end
            default: ;
        endcase
    end

    // outputs
    always_comb begin
        o_result                 = '0;
        o_result.state_code      = n_phase;
        o_result.mux_channel     = n_scan_channel;
        o_result.test_parked     = n_parked_flag;
        o_result.mux_open        = w_tick && (r_phase == PH_OPEN);
        o_result.trigger_convert = w_tick && (r_phase == PH_TRIG);
        o_result.store_current   = w_st_cur;
        o_result.store_voltage   = w_st_volt;
        o_result.sample_code     = (w_st_cur || w_st_volt) ? i_item.adc_data : '0;
        o_result.reinit          = w_tick && w_timeout
                                   && (((r_phase == PH_READI) && i_item.current_ready_n)
                                    || ((r_phase == PH_READV) && i_item.voltage_ready_n));
        if (w_func == FN_READ) begin
            o_result.read_current = r_cur_valid[w_slot] ? r_cur_codes[w_slot] : '0;
            o_result.read_voltage = r_volt_valid[w_slot] ? r_volt_codes[w_slot] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase          <= PH_IDLE;
            r_settle_count   <= '0;
            r_wait_count     <= '0;
            r_scan_channel   <= '0;
            r_pinned_channel <= '0;
            r_saved_channel  <= '0;
            r_test_mode      <= 1'b0;
            r_test_switched  <= 1'b0;
            r_parked_flag    <= 1'b0;
            r_cur_valid      <= '0;
            r_volt_valid     <= '0;
        end else if (i_step) begin
            r_phase          <= n_phase;
            r_settle_count   <= n_settle_count;
            r_wait_count     <= n_wait_count;
            r_scan_channel   <= n_scan_channel;
            r_pinned_channel <= n_pinned_channel;
            r_saved_channel  <= n_saved_channel;
            r_test_mode      <= n_test_mode;
            r_test_switched  <= n_test_switched;
            r_parked_flag    <= n_parked_flag;
            if (w_st_cur) begin
                r_cur_valid[w_slot] <= 1'b1;
            end
            if (w_st_volt) begin
                r_volt_valid[w_slot] <= 1'b1;
            end
        end
    end

    // code store payload; an entry reads as zero until its valid bit is set
    always_ff @(posedge i_clk) begin
        if (i_step && w_st_cur) begin
            r_cur_codes[w_slot] <= i_item.adc_data;
        end
        if (i_step && w_st_volt) begin
            r_volt_codes[w_slot] <= i_item.adc_data;
        end
    end

endmodule

// ===== hdl/adc_channel_scan_sequencer.sv =====
// Top level of the ADC channel scan sequencer: handshakes, config registers, output skid.
// Depends on acss_pkg, acss_core and adc_channel_scan_sequencer_defines.svh.
`include "adc_channel_scan_sequencer_defines.svh"

// Takes one command transaction per clock cycle while o_in_stall is low; its result is
// registered into the output register, or into the skid register if the output stalls.
// Each command is a single state machine step with one settle or wait counter compare
// and at most one code store write, all done in the cycle of acceptance. The output
// side holds two results (output register plus skid register), so input is stalled
// only when both are full. Configuration writes are always ready and take effect on
// the next accepted command; the code store reads as zero after reset.
module adc_channel_scan_sequencer
    import acss_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,

    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [2:0]            i_func,
    input  logic                  i_current_ready_n,
    input  logic                  i_voltage_ready_n,
    input  logic [CODE_W-1:0]     i_adc_data,
    input  logic [CH_W-1:0]       i_test_channel,

    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [2:0]            o_state_code,
    output logic                  o_mux_open,
    output logic [CH_W-1:0]       o_mux_channel,
    output logic                  o_trigger_convert,
    output logic                  o_store_current,
    output logic                  o_store_voltage,
    output logic [CODE_W-1:0]     o_sample_code,
    output logic                  o_reinit,
    output logic                  o_test_parked,
    output logic [CODE_W-1:0]     o_read_current,
    output logic [CODE_W-1:0]     o_read_voltage
);

    t_cfg    r_cfg;
    t_item   w_item;
    t_result w_result;
    t_result r_out, r_skid;
    logic    r_out_valid, r_skid_valid;
    logic    w_in_acc;
    logic    w_out_free;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.channel_count <= CHANNEL_COUNT_RST;
            r_cfg.settle_ticks  <= SETTLE_TICKS_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_CHANNEL_COUNT: r_cfg.channel_count <= i_cfg_data[4:0];
                CFG_SETTLE_TICKS:  r_cfg.settle_ticks  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_item.func            = i_func;
    assign w_item.current_ready_n = i_current_ready_n;
    assign w_item.voltage_ready_n = i_voltage_ready_n;
    assign w_item.adc_data        = i_adc_data;
    assign w_item.test_channel    = i_test_channel;

    assign o_in_stall = r_skid_valid;
    assign w_in_acc   = i_in_valid && !r_skid_valid;
    assign w_out_free = !r_out_valid || !i_out_stall;

    acss_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_in_acc),
        .i_item   (w_item),
        .i_cfg    (r_cfg),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid  <= r_skid_valid || w_in_acc;
            r_skid_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            r_out <= r_skid_valid ? r_skid : w_result;
        end else if (w_in_acc) begin
            r_skid <= w_result;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_state_code      = r_out.state_code;
    assign o_mux_open        = r_out.mux_open;
    assign o_mux_channel     = r_out.mux_channel;
    assign o_trigger_convert = r_out.trigger_convert;
    assign o_store_current   = r_out.store_current;
    assign o_store_voltage   = r_out.store_voltage;
    assign o_sample_code     = r_out.sample_code;
    assign o_reinit          = r_out.reinit;
    assign o_test_parked     = r_out.test_parked;
    assign o_read_current    = r_out.read_current;
    assign o_read_voltage    = r_out.read_voltage;

    `ACSS_ASSERT_ALWAYS(a_skid_behind_out, r_skid_valid |-> r_out_valid, "skid full while output empty")
    `ACSS_ASSERT(a_stalled_accept_to_skid, (r_out_valid && i_out_stall && w_in_acc) |=> r_skid_valid, "stalled result not parked in skid")
    `ACSS_ASSERT(a_one_store, r_out_valid |-> !(r_out.store_current && r_out.store_voltage), "both code stores in one result")
    `ACSS_ASSERT(a_trig_readi, (r_out_valid && r_out.trigger_convert) |-> (r_out.state_code == PH_READI), "trigger without read phase")
    `ACSS_ASSERT(a_reinit_idle, (r_out_valid && r_out.reinit) |-> (r_out.state_code == PH_IDLE && r_out.mux_channel == '0), "timeout did not return to idle")

endmodule
